/* hdl/csb_pkg.sv */
`default_nettype none

package csb_pkg;

    // Bank size and derived widths
    localparam int NUM_SEMS    = 64;
    localparam int IDX_W       = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int SEM_INDEX_W = 8;
    localparam int CNT_W       = 16;
    localparam int SLOT_W      = 6;

    typedef logic [IDX_W-1:0]       t_idx;
    typedef logic [SEM_INDEX_W-1:0] t_sem_index;
    typedef logic [CNT_W-1:0]       t_count;
    typedef logic [SLOT_W-1:0]      t_slot;

    localparam t_count COUNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_OPEN  = 2'd0,
        OP_CLOSE = 2'd1,
        OP_UP    = 2'd2,
        OP_DOWN  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_BADARG = 2'd1,
        STS_CLOSED = 2'd2,
        STS_NOFREE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_EXEC,
        ST_RESP
    } t_state;

    typedef enum logic {
        ALU_INC,
        ALU_DEC
    } t_alu_op;

    // Operand status from the shared unit
    typedef struct packed {
        logic a_zero;
        logic a_max;
    } t_alu_flags;

    typedef struct packed {
        t_status status;
        t_slot   slot_index;
        logic    must_block;
        logic    wake_waiters;
    } t_result;

endpackage

`default_nettype wire

/* hdl/csb_if.sv */
`default_nettype none

// Request channel: operation, slot and initial count
interface csb_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           opcode;
    logic [csb_pkg::SEM_INDEX_W-1:0]      sem_index;
    logic signed [csb_pkg::CNT_W-1:0]     init_value;

    modport source (output valid, opcode, sem_index, init_value, input ready);
    modport sink   (input valid, opcode, sem_index, init_value, output ready);
endinterface

// Response channel: one result item per request
interface csb_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [csb_pkg::SLOT_W-1:0]    slot_index;
    logic                          must_block;
    logic                          wake_waiters;

    modport source (output valid, status, slot_index, must_block, wake_waiters, input ready);
    modport sink   (input valid, status, slot_index, must_block, wake_waiters, output ready);
endinterface

`default_nettype wire

/* hdl/csb_ram.sv */
`default_nettype none

module csb_ram #(
    parameter int  WIDTH  = 16,
    parameter int  DEPTH  = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write on enable, register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

/* hdl/csb_alu.sv */
`default_nettype none

module csb_alu (
    input  wire csb_pkg::t_alu_op    i_op,
    input  wire csb_pkg::t_count     i_a,
    output csb_pkg::t_count          o_res,
    output csb_pkg::t_alu_flags      o_flags
);

    // Step the operand by one in either direction
    always_comb begin
        case (i_op)
            csb_pkg::ALU_INC: o_res = i_a + csb_pkg::t_count'(1);
            csb_pkg::ALU_DEC: o_res = i_a - csb_pkg::t_count'(1);
            default:          o_res = i_a;
        endcase
    end

    // Flag the operand at either end of its range
    assign o_flags.a_zero = (i_a == '0);
    assign o_flags.a_max  = (i_a == csb_pkg::COUNT_MAX);

endmodule

`default_nettype wire

/* hdl/counting_semaphore_bank.sv */
`default_nettype none

// Channel   Dir  Payload                                         Handshake
// i_req     in   opcode[1:0] sem_index[7:0] init_value[15:0] s   valid/ready
// o_rsp     out  status[1:0] slot_index[5:0] must_block wake     valid/ready
//
// Requests are handled one at a time by a small sequencer around one
// increment/decrement unit and a single-port count memory.
// Every request passes a check step and a response step; up and down add an execute step,
// and an open with a valid count adds a scan that tests one slot per cycle until it claims
// a closed slot or reaches the last slot with none free.
// Reset is synchronous and needs no clearing pass; the open flags gate every count read.
// A result waits in the output register; i_req is ready only in the idle state.

module counting_semaphore_bank (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    csb_req_if.sink   i_req,
    csb_rsp_if.source o_rsp
);

    csb_pkg::t_state     r_state;
    csb_pkg::t_state     n_state;
    csb_pkg::t_opcode    r_op;
    csb_pkg::t_idx       r_ptr;
    csb_pkg::t_idx       n_ptr;
    logic                r_badidx;
    csb_pkg::t_count     r_ival;
    csb_pkg::t_result    r_res;
    csb_pkg::t_result    n_res;
    csb_pkg::t_result    r_out;
    logic                r_out_valid;
    logic                r_slot_open [csb_pkg::NUM_SEMS];

    logic                in_fire;
    logic                load_out;
    logic                flag_cur;
    logic                ptr_last;
    logic                ival_neg;
    logic                flag_set;
    logic                flag_clr;
    logic                ram_we;
    csb_pkg::t_count     ram_wdata;
    csb_pkg::t_count     ram_rdata;
    csb_pkg::t_alu_op    alu_op;
    csb_pkg::t_count     alu_a;
    csb_pkg::t_count     alu_res;
    csb_pkg::t_alu_flags alu_flags;

    assign i_req.ready = (r_state == csb_pkg::ST_IDLE);
    assign in_fire     = i_req.valid && i_req.ready;
    assign flag_cur    = r_slot_open[r_ptr];
    assign ptr_last    = (r_ptr == csb_pkg::t_idx'(csb_pkg::NUM_SEMS - 1));
    assign ival_neg    = r_ival[csb_pkg::CNT_W-1];

    // Shared increment/decrement unit
    csb_alu u_alu (
        .i_op    (alu_op),
        .i_a     (alu_a),
        .o_res   (alu_res),
        .o_flags (alu_flags)
    );

    // Count store, addressed by the slot pointer
    csb_ram #(
        .WIDTH (csb_pkg::CNT_W),
        .DEPTH (csb_pkg::NUM_SEMS)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (r_ptr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            csb_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_state = csb_pkg::ST_CHECK;
                end
            end
            csb_pkg::ST_CHECK: begin
                if (r_badidx) begin
                    n_state = csb_pkg::ST_RESP;
                end else if (r_op == csb_pkg::OP_OPEN) begin
                    n_state = ival_neg ? csb_pkg::ST_RESP : csb_pkg::ST_SCAN;
                end else if (!flag_cur || r_op == csb_pkg::OP_CLOSE) begin
                    n_state = csb_pkg::ST_RESP;
                end else begin
                    n_state = csb_pkg::ST_EXEC;
                end
            end
            csb_pkg::ST_SCAN: begin
                if (!flag_cur || ptr_last) begin
                    n_state = csb_pkg::ST_RESP;
                end
            end
            csb_pkg::ST_EXEC: n_state = csb_pkg::ST_RESP;
            csb_pkg::ST_RESP: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = csb_pkg::ST_IDLE;
                end
            end
            default: n_state = csb_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        n_res     = r_res;
        n_ptr     = r_ptr;
        alu_op    = csb_pkg::ALU_INC;
        alu_a     = csb_pkg::t_count'(r_ptr);
        ram_we    = 1'b0;
        ram_wdata = r_ival;
        flag_set  = 1'b0;
        flag_clr  = 1'b0;
        load_out  = 1'b0;
        case (r_state)
            csb_pkg::ST_IDLE: begin
                n_res = r_res;
            end
            csb_pkg::ST_CHECK: begin
                n_res = '{status: csb_pkg::STS_OK, slot_index: '0,
                          must_block: 1'b0, wake_waiters: 1'b0};
                if (r_badidx) begin
                    n_res.status = csb_pkg::STS_BADARG;
                end else if (r_op == csb_pkg::OP_OPEN) begin
                    if (ival_neg) begin
                        n_res.status = csb_pkg::STS_BADARG;
                    end
                end else if (!flag_cur) begin
                    n_res.status = csb_pkg::STS_CLOSED;
                end else if (r_op == csb_pkg::OP_CLOSE) begin
                    flag_clr = 1'b1;
                end
            end
            csb_pkg::ST_SCAN: begin
                // Claim a closed slot, report no free slot at the last one, else advance the pointer
                if (!flag_cur) begin
                    flag_set         = 1'b1;
                    ram_we           = 1'b1;
                    ram_wdata        = r_ival;
                    n_res.slot_index = csb_pkg::t_slot'(r_ptr);
                end else if (ptr_last) begin
                    n_res.status = csb_pkg::STS_NOFREE;
                end else begin
                    n_ptr = csb_pkg::t_idx'(alu_res);
                end
            end
            csb_pkg::ST_EXEC: begin
                alu_a     = ram_rdata;
                alu_op    = (r_op == csb_pkg::OP_UP) ? csb_pkg::ALU_INC : csb_pkg::ALU_DEC;
                ram_wdata = alu_res;
                if (r_op == csb_pkg::OP_UP) begin
                    // Saturate at the maximum; wake on zero to one
                    if (!alu_flags.a_max) begin
                        ram_we             = 1'b1;
                        n_res.wake_waiters = alu_flags.a_zero;
                    end
                end else begin
                    // Decrement, or tell the caller to block
                    if (!alu_flags.a_zero) begin
                        ram_we = 1'b1;
                    end else begin
                        n_res.must_block = 1'b1;
                    end
                end
            end
            csb_pkg::ST_RESP: begin
                load_out = !r_out_valid || o_rsp.ready;
            end
            default: begin
                n_res = r_res;
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Latch the request item, hold the working result
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op     <= csb_pkg::t_opcode'(i_req.opcode);
            r_ptr    <= csb_pkg::t_idx'(i_req.sem_index);
            r_badidx <= ({1'b0, i_req.sem_index} >=
                         (csb_pkg::SEM_INDEX_W + 1)'(csb_pkg::NUM_SEMS));
            r_ival   <= csb_pkg::t_count'(i_req.init_value);
        end else begin
            r_ptr <= n_ptr;
        end
        r_res <= n_res;
    end

    // Open flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < csb_pkg::NUM_SEMS; k++) begin
                r_slot_open[k] <= 1'b0;
            end
        end else if (flag_set) begin
            r_slot_open[r_ptr] <= 1'b1;
        end else if (flag_clr) begin
            r_slot_open[r_ptr] <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= r_res;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.slot_index   = r_out.slot_index;
    assign o_rsp.must_block   = r_out.must_block;
    assign o_rsp.wake_waiters = r_out.wake_waiters;

    // An accepted item always goes to the check step next
    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_state == csb_pkg::ST_CHECK)
        else $error("accepted item did not enter the check step");

    // A count is only written into a slot that is open afterward
    a_write_open_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> r_slot_open[r_ptr])
        else $error("count written to a closed slot");

    // Block and wake never come together
    a_block_wake_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.must_block && o_rsp.wake_waiters))
        else $error("must_block and wake_waiters both set");

    // A failed request reports slot zero
    a_fail_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != csb_pkg::STS_OK) |-> o_rsp.slot_index == '0)
        else $error("failed request reports a nonzero slot");

endmodule

`default_nettype wire
